// ===== hdl/ipv4_udp_frame_checksum_defines.svh =====
// ----------------------------------------------------------------------------
// ipv4_udp_frame_checksum_defines
// assertion macros for the checksum block checker
// ----------------------------------------------------------------------------
`ifndef IPV4_UDP_FRAME_CHECKSUM_DEFINES_SVH
`define IPV4_UDP_FRAME_CHECKSUM_DEFINES_SVH

// clocked property with asynchronous reset gating
`define IUCSUM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a stalled word keeps its contents on the next edge
`define IUCSUM_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
	`IUCSUM_ASSERT(lbl, clk, rst_n, (vld) && !(rdy) |=> $stable(sig), msg)

`endif

// ===== hdl/iucsum_pkg.sv =====
// ----------------------------------------------------------------------------
// iucsum_pkg
// types, status codes and the one's complement add for the checksum block
// ----------------------------------------------------------------------------
package iucsum_pkg;

	// input word: one frame byte with its end mark
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_word_t;

	// result word: both sums and their status
	typedef struct packed {
		logic [15:0] ip_sum;
		logic [15:0] udp_sum;
		logic [1:0]  ip_status;
		logic [1:0]  udp_status;
	} out_word_t;

	// ip header status codes
	localparam logic [1:0] IP_ST_OK      = 2'd0;
	localparam logic [1:0] IP_ST_BAD_IHL = 2'd1;
	localparam logic [1:0] IP_ST_SHORT   = 2'd2;

	// udp status codes
	localparam logic [1:0] UDP_ST_OK      = 2'd0;
	localparam logic [1:0] UDP_ST_BAD_IHL = 2'd1;
	localparam logic [1:0] UDP_ST_LEN0    = 2'd2;
	localparam logic [1:0] UDP_ST_SHORT   = 2'd3;

	// header and datagram bounds
	localparam logic [3:0]  IHL_MIN       = 4'd5;
	localparam logic [5:0]  PSEUDO_FIRST  = 6'd13;
	localparam logic [5:0]  PSEUDO_LAST   = 6'd19;
	localparam logic [5:0]  PROTO_OFFSET  = 6'd9;
	localparam logic [15:0] UDP_HEAD_LEN  = 16'd6;
	localparam logic [15:0] UDP_LEN_LO    = 16'd5;
	localparam logic [15:0] DGRAM_CNT_MAX = 16'hFFFF;
	localparam logic [5:0]  IP_START_RST  = 6'd14;

	// add the complemented word and fold the carry back once
	function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] w);
		logic [16:0] s;
		s = {1'b0, acc} + {1'b0, ~w};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ===== hdl/iucsum_stream_if.sv =====
// ----------------------------------------------------------------------------
// iucsum_stream_if
// valid/ready stream channel carrying one word of any packed type
// ----------------------------------------------------------------------------
interface iucsum_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/ipv4_udp_frame_checksum.sv =====
// ----------------------------------------------------------------------------
// ipv4_udp_frame_checksum
// ipv4 header and udp checksum accumulation over an ethernet byte stream
// ----------------------------------------------------------------------------
// usage
// - frame: sink channel, one frame byte per word, last_byte marks the end
// - result: source channel, one word per frame with ip_sum, udp_sum and the
//   two status codes; sums read zero whenever their status is not ok
// - cfg_wr_en / cfg_wr_data: ip header offset, written between frames
// throughput: one byte per cycle unless a last byte waits on a held result,
//   set by the header and datagram accumulators updating from the input
//   stage register
// path: a last byte passes the input stage register, then the result
//   register, before its result is valid
// reset: ip header offset returns to 14, all frame state is cleared and the
//   result channel is empty
// stall: while a result waits, bytes that do not end a frame keep flowing;
//   a last byte waits in the input stage until the result is taken
// bytes at or past MAX_FRAME_BYTES are dropped; the end mark still counts
// ----------------------------------------------------------------------------
module ipv4_udp_frame_checksum #(
	parameter int MAX_FRAME_BYTES = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [5:0]          cfg_wr_data,
	iucsum_stream_if.sink       frame,
	iucsum_stream_if.source     result
);

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

	// input stage
	logic                  valid_s1;
	iucsum_pkg::in_word_t  word_s1;
	logic                  advance;

	// result register
	logic                  out_valid_q;
	iucsum_pkg::out_word_t out_word_q;

	// configuration and frame state
	logic [5:0]       ip_start_q;
	logic [POS_W-1:0] pos_q,       pos_n;
	logic [15:0]      hdr_acc_q,   hdr_acc_n;
	logic [15:0]      dg_acc_q,    dg_acc_n;
	logic [5:0]       hdr_bytes_q, hdr_bytes_n;
	logic [15:0]      dg_bytes_q,  dg_bytes_n;
	logic [7:0]       held_q,      held_n;
	logic [1:0]       err_q,       err_n;
	logic [3:0]       ihl_q,       ihl_n;
	logic [15:0]      udp_len_q,   udp_len_n;
	logic             len_known_q, len_known_n;
	logic [7:0]       head_q [5],  head_n [5];

	iucsum_pkg::out_word_t res_n;

	// handshake: only a last byte waits on the result register
	assign advance      = valid_s1 && (!word_s1.last_byte || !out_valid_q || result.ready);
	assign frame.ready  = !valid_s1 || advance;
	assign result.valid = out_valid_q;
	assign result.payload = out_word_q;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			word_s1 <= frame.payload;
		end
	end

	// header offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_start_q <= iucsum_pkg::IP_START_RST;
		end else if (cfg_wr_en) begin
			ip_start_q <= cfg_wr_data;
		end
	end

	// byte update of the frame state and result formation
	always_comb begin
		logic [7:0]  b;
		logic        started;
		logic        skip;
		logic [3:0]  ihl_eff;
		logic [5:0]  lim;
		logic [5:0]  o;
		logic [15:0] w;
		logic [15:0] u;
		logic [15:0] len;

		b       = word_s1.frame_byte;
		pos_n       = pos_q;
		hdr_acc_n   = hdr_acc_q;
		dg_acc_n    = dg_acc_q;
		hdr_bytes_n = hdr_bytes_q;
		dg_bytes_n  = dg_bytes_q;
		held_n      = held_q;
		err_n       = err_q;
		ihl_n       = ihl_q;
		udp_len_n   = udp_len_q;
		len_known_n = len_known_q;
		for (int i = 0; i < 5; i++) begin
			head_n[i] = head_q[i];
		end
		started = (hdr_bytes_q != 6'd0) || err_q[0];
		skip    = 1'b0;
		ihl_eff = ihl_q;
		o       = hdr_bytes_q;
		w       = {held_q, b};
		u       = dg_bytes_q;
		len     = {head_q[4], b};
		lim     = 6'd0;

		if (pos_q < POS_MAX) begin
			pos_n = pos_q + 1'b1;
			if (!err_q[0]) begin
				// header start detection and length check
				if (!started) begin
					if (pos_q < {{(POS_W-6){1'b0}}, ip_start_q}) begin
						skip = 1'b1;
					end else begin
						ihl_n   = b[3:0];
						ihl_eff = b[3:0];
						if (b[3:0] < iucsum_pkg::IHL_MIN) begin
							err_n[0] = 1'b1;
							skip     = 1'b1;
						end
					end
				end
				lim = {ihl_eff, 2'b00};
				if (!skip) begin
					if (o < lim) begin
						// header bytes, pseudo-header words feed the udp sum
						if (!o[0]) begin
							held_n = b;
						end else begin
							hdr_acc_n = iucsum_pkg::ones_add(hdr_acc_q, w);
							if (o >= iucsum_pkg::PSEUDO_FIRST && o <= iucsum_pkg::PSEUDO_LAST) begin
								dg_acc_n = iucsum_pkg::ones_add(dg_acc_q, w);
							end
							if (o == iucsum_pkg::PROTO_OFFSET) begin
								dg_acc_n = iucsum_pkg::ones_add(dg_acc_q, {8'd0, b});
							end
						end
						hdr_bytes_n = o + 6'd1;
					end else if (u != iucsum_pkg::DGRAM_CNT_MAX) begin
						// udp region
						if (u < iucsum_pkg::UDP_HEAD_LEN) begin
							if (u < iucsum_pkg::UDP_LEN_LO) begin
								head_n[u[2:0]] = b;
							end else begin
								// length known: sum it and the held udp header words
								udp_len_n   = len;
								len_known_n = 1'b1;
								if (len == 16'd0) begin
									err_n[1] = 1'b1;
								end
								dg_acc_n = iucsum_pkg::ones_add(dg_acc_q, len);
								if (len > 16'd1) begin
									dg_acc_n = iucsum_pkg::ones_add(dg_acc_n, {head_q[0], head_q[1]});
								end else if (len > 16'd0) begin
									dg_acc_n = iucsum_pkg::ones_add(dg_acc_n, {head_q[0], 8'd0});
								end
								if (len > 16'd3) begin
									dg_acc_n = iucsum_pkg::ones_add(dg_acc_n, {head_q[2], head_q[3]});
								end else if (len > 16'd2) begin
									dg_acc_n = iucsum_pkg::ones_add(dg_acc_n, {head_q[2], 8'd0});
								end
								if (len > 16'd5) begin
									dg_acc_n = iucsum_pkg::ones_add(dg_acc_n, {head_q[4], b});
								end else if (len > 16'd4) begin
									dg_acc_n = iucsum_pkg::ones_add(dg_acc_n, {head_q[4], 8'd0});
								end
							end
						end else if (u < udp_len_q) begin
							// payload words, an odd final byte padded with zero
							if (!u[0]) begin
								held_n = b;
								if (u + 16'd1 == udp_len_q) begin
									dg_acc_n = iucsum_pkg::ones_add(dg_acc_q, {b, 8'd0});
								end
							end else begin
								dg_acc_n = iucsum_pkg::ones_add(dg_acc_q, w);
							end
						end
						dg_bytes_n = u + 16'd1;
					end
				end
			end
		end

		// ip header status
		res_n.ip_sum  = 16'd0;
		res_n.udp_sum = 16'd0;
		if (err_n[0]) begin
			res_n.ip_status = iucsum_pkg::IP_ST_BAD_IHL;
		end else if (hdr_bytes_n == 6'd0 || hdr_bytes_n < {ihl_n, 2'b00}) begin
			res_n.ip_status = iucsum_pkg::IP_ST_SHORT;
		end else begin
			res_n.ip_status = iucsum_pkg::IP_ST_OK;
			res_n.ip_sum    = hdr_acc_n;
		end

		// udp status
		if (err_n[0]) begin
			res_n.udp_status = iucsum_pkg::UDP_ST_BAD_IHL;
		end else if (len_known_n && udp_len_n == 16'd0) begin
			res_n.udp_status = iucsum_pkg::UDP_ST_LEN0;
		end else if (!len_known_n || dg_bytes_n < udp_len_n) begin
			res_n.udp_status = iucsum_pkg::UDP_ST_SHORT;
		end else begin
			res_n.udp_status = iucsum_pkg::UDP_ST_OK;
			res_n.udp_sum    = dg_acc_n;
		end
	end

	// frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hdr_acc_q   <= '0;
			dg_acc_q    <= '0;
			hdr_bytes_q <= '0;
			dg_bytes_q  <= '0;
			held_q      <= '0;
			err_q       <= '0;
			ihl_q       <= '0;
			udp_len_q   <= '0;
			len_known_q <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				head_q[i] <= '0;
			end
		end else if (advance) begin
			if (word_s1.last_byte) begin
				pos_q       <= '0;
				hdr_acc_q   <= '0;
				dg_acc_q    <= '0;
				hdr_bytes_q <= '0;
				dg_bytes_q  <= '0;
				held_q      <= '0;
				err_q       <= '0;
				ihl_q       <= '0;
				udp_len_q   <= '0;
				len_known_q <= 1'b0;
				for (int i = 0; i < 5; i++) begin
					head_q[i] <= '0;
				end
			end else begin
				pos_q       <= pos_n;
				hdr_acc_q   <= hdr_acc_n;
				dg_acc_q    <= dg_acc_n;
				hdr_bytes_q <= hdr_bytes_n;
				dg_bytes_q  <= dg_bytes_n;
				held_q      <= held_n;
				err_q       <= err_n;
				ihl_q       <= ihl_n;
				udp_len_q   <= udp_len_n;
				len_known_q <= len_known_n;
				for (int i = 0; i < 5; i++) begin
					head_q[i] <= head_n[i];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last_byte) begin
			out_word_q <= res_n;
		end
	end

endmodule

// ===== hdl/iucsum_checker.sv =====
// ----------------------------------------------------------------------------
// iucsum_checker
// port-level checks on the result channel of the checksum block
// ----------------------------------------------------------------------------
`include "ipv4_udp_frame_checksum_defines.svh"

module iucsum_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input iucsum_pkg::out_word_t out_word
);

	// stalled result keeps valid and contents
	`IUCSUM_ASSERT_HOLD(a_valid_hold, clk, arst_n, out_valid, out_ready, out_valid, "result valid dropped while stalled")
	`IUCSUM_ASSERT_HOLD(a_word_hold, clk, arst_n, out_valid, out_ready, out_word, "result word changed while stalled")

	// a failing header reports a zero sum
	`IUCSUM_ASSERT(a_ip_sum_zero, clk, arst_n, out_valid && (out_word.ip_status != iucsum_pkg::IP_ST_OK) |-> (out_word.ip_sum == 16'd0), "ip sum not zero on bad status")

	// a failing udp region reports a zero sum
	`IUCSUM_ASSERT(a_udp_sum_zero, clk, arst_n, out_valid && (out_word.udp_status != iucsum_pkg::UDP_ST_OK) |-> (out_word.udp_sum == 16'd0), "udp sum not zero on bad status")

	// a bad header length shows on both status fields together
	`IUCSUM_ASSERT(a_ihl_both, clk, arst_n, out_valid |-> ((out_word.ip_status == iucsum_pkg::IP_ST_BAD_IHL) == (out_word.udp_status == iucsum_pkg::UDP_ST_BAD_IHL)), "bad header length status mismatch")

endmodule

bind ipv4_udp_frame_checksum iucsum_checker u_iucsum_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_word  (result.payload)
);
